// ===== rtl/lmfs_pkg.sv =====
package lmfs_pkg;

    localparam int ROWS = 8;

    // action codes
    localparam logic [2:0] ACT_PIXEL  = 3'd0;
    localparam logic [2:0] ACT_ROLL   = 3'd1;
    localparam logic [2:0] ACT_REFR   = 3'd2;
    localparam logic [2:0] ACT_INIT   = 3'd3;
    localparam logic [2:0] ACT_DTEST  = 3'd4;
    localparam logic [2:0] ACT_INTENS = 3'd5;

    // driver register addresses, high byte of the word
    localparam logic [15:0] CMD_DECODE   = 16'h0900;
    localparam logic [15:0] CMD_INTENS   = 16'h0A00;
    localparam logic [15:0] CMD_SCANLIM  = 16'h0B00;
    localparam logic [15:0] CMD_SHUTDOWN = 16'h0C00;
    localparam logic [15:0] CMD_DTEST    = 16'h0F00;

    localparam logic [15:0] WORD_SHUTDOWN_OFF = CMD_SHUTDOWN | 16'h0001;
    localparam logic [15:0] WORD_INTENS_DFLT  = CMD_INTENS | 16'h0003;
    localparam logic [15:0] WORD_SCANLIM_ALL  = CMD_SCANLIM | 16'h0007;

    localparam logic [3:0] INTENS_RESET = 4'd3;

    // frame read address source
    localparam logic [1:0] RD_PIX  = 2'd0;
    localparam logic [1:0] RD_CUR  = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    typedef struct packed {
        logic [2:0] action;
        logic [6:0] x_pos;
        logic [3:0] y_pos;
        logic       value;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [15:0] spi_word;
        logic        latch_end;
        logic        point_ok;
        logic        last;
    } t_out;

    typedef struct packed {
        logic       load_item;
        logic       clr_cnt;
        logic       inc_col;
        logic       next_row;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_pix;
        logic       roll_step;
        logic       out_load;
        logic       out_status;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       pix_ok;
        logic       col_mod_last;
        logic       col_lt_mod;
        logic       col_roll_end;
        logic       row_last;
        logic       grp_last;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/lmfs_ctrl.sv =====
module lmfs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lmfs_pkg::t_sts  i_sts,
    output lmfs_pkg::t_cmd  o_cmd
);
    import lmfs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PX_RD  = 3'd1;
    localparam logic [2:0] S_PX_WR  = 3'd2;
    localparam logic [2:0] S_PX_OUT = 3'd3;
    localparam logic [2:0] S_EM_RD  = 3'd4;
    localparam logic [2:0] S_EM_OUT = 3'd5;
    localparam logic [2:0] S_ROLL   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.clr_cnt   = 1'b1;
                    case (i_sts.action)
                        ACT_PIXEL: n_state = S_PX_RD;
                        ACT_ROLL:  n_state = S_ROLL;
                        ACT_REFR:  n_state = S_EM_RD;
                        default: begin
                            if (i_sts.action inside {ACT_INIT, ACT_DTEST, ACT_INTENS})
                                n_state = S_EM_OUT;
                        end
                    endcase
                end
            end
            S_PX_RD: begin
                if (i_sts.pix_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PIX;
                    n_state      = S_PX_WR;
                end else begin
                    n_state = S_PX_OUT;
                end
            end
            S_PX_WR: begin
                o_cmd.wr_pix = 1'b1;
                n_state      = S_PX_OUT;
            end
            S_PX_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_EM_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
                n_state      = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.col_mod_last && i_sts.grp_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // prefetch the next frame byte while this word goes out
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_NEXT;
                        if (i_sts.col_mod_last)
                            o_cmd.next_row = 1'b1;
                        else
                            o_cmd.inc_col = 1'b1;
                    end
                end
            end
            S_ROLL: begin
                o_cmd.roll_step = 1'b1;
                o_cmd.rd_sel    = RD_CUR;
                o_cmd.rd_en     = i_sts.col_lt_mod;
                if (i_sts.col_roll_end) begin
                    if (i_sts.row_last)
                        n_state = S_IDLE;
                    else
                        o_cmd.next_row = 1'b1;
                end else begin
                    o_cmd.inc_col = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

endmodule

// ===== rtl/lmfs_datapath.sv =====
module lmfs_datapath #(
    parameter int MODULES = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmfs_pkg::t_in   i_in_data,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_data,
    input  lmfs_pkg::t_cmd  i_cmd,
    output lmfs_pkg::t_sts  o_sts,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output lmfs_pkg::t_out  o_out_data
);
    import lmfs_pkg::*;

    localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int CW    = $clog2(MODULES + 2);
    localparam int AW    = 3 + MW;
    localparam int DEPTH = 1 << AW;
    localparam int XLIM  = 8 * MODULES;

    t_in              r_in;
    logic [3:0]       r_intens;
    logic [2:0]       r_row;
    logic [2:0]       n_row;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    n_col;
    logic [7:0]       r_prev;
    logic             r_msb0;
    logic             r_out_valid;
    t_out             r_out;

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rdata;
    logic             r_rvld;
    logic [7:0]       rd_byte;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;

    logic             pix_ok;
    logic [7:0]       pix_mask;
    logic [CW-1:0]    col_m2;
    logic             roll_wr;
    logic             roll_end;
    logic             grp_last;
    logic [15:0]      word;
    logic             out_free;

    // input latch and intensity register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item)
            r_in <= i_in_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_intens <= INTENS_RESET;
        else if (i_cfg_we)
            r_intens <= i_cfg_data;
    end

    // row / column counters
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cmd.clr_cnt) begin
            n_row = '0;
            n_col = '0;
        end else if (i_cmd.next_row) begin
            n_row = r_row + 3'd1;
            n_col = '0;
        end else if (i_cmd.inc_col) begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // frame memory, entry {row, module}; unwritten entries read as zero
    assign rd_byte = r_rvld ? r_rdata : 8'h00;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PIX:  rd_addr = {r_in.y_pos[2:0], r_in.x_pos[3 +: MW]};
            RD_CUR:  rd_addr = {r_row, r_col[MW-1:0]};
            RD_NEXT: rd_addr = {n_row, n_col[MW-1:0]};
            default: rd_addr = {r_row, r_col[MW-1:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rvld  <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (wr_en)
            r_vld[wr_addr] <= 1'b1;
    end

    // pixel edit
    assign pix_ok   = ({1'b0, r_in.x_pos} < 8'(XLIM)) && !r_in.y_pos[3];
    assign pix_mask = 8'h80 >> r_in.x_pos[2:0];

    // roll: byte m takes (v[m] << 1) | msb of v[m+1], last byte wraps msb of byte 0
    assign col_m2   = r_col - CW'(2);
    assign roll_end = (r_col == CW'(MODULES + 1));
    assign roll_wr  = i_cmd.roll_step && (r_col >= CW'(2));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_row, r_col[MW-1:0]};
        wr_data = rd_byte;
        if (i_cmd.wr_pix) begin
            wr_en   = 1'b1;
            wr_addr = {r_in.y_pos[2:0], r_in.x_pos[3 +: MW]};
            wr_data = r_in.value ? (rd_byte | pix_mask) : (rd_byte & ~pix_mask);
        end else if (roll_wr) begin
            wr_en = 1'b1;
            if (roll_end) begin
                wr_addr = {r_row, MW'(MODULES - 1)};
                wr_data = {r_prev[6:0], r_msb0};
            end else begin
                wr_addr = {r_row, col_m2[MW-1:0]};
                wr_data = {r_prev[6:0], rd_byte[7]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.roll_step && (r_col >= CW'(1)) && (r_col <= CW'(MODULES))) begin
            r_prev <= rd_byte;
            if (r_col == CW'(1))
                r_msb0 <= rd_byte[7];
        end
    end

    // command word for the current group and module
    always_comb begin
        word     = 16'h0000;
        grp_last = 1'b1;
        case (r_in.action)
            ACT_REFR: begin
                word     = {4'h0, {1'b0, r_row} + 4'd1, rd_byte};
                grp_last = (r_row == 3'd7);
            end
            ACT_INIT: begin
                grp_last = (r_row == 3'd3);
                case (r_row[1:0])
                    2'd0:    word = WORD_SHUTDOWN_OFF;
                    2'd1:    word = CMD_DECODE;
                    2'd2:    word = WORD_INTENS_DFLT;
                    default: word = WORD_SCANLIM_ALL;
                endcase
            end
            ACT_DTEST:  word = CMD_DTEST | {15'h0, r_in.value};
            ACT_INTENS: word = CMD_INTENS | {12'h0, r_intens};
            default:    word = 16'h0000;
        endcase
    end

    // output register
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (i_cmd.out_load)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_status) begin
                r_out.kind      <= 1'b0;
                r_out.spi_word  <= 16'h0000;
                r_out.latch_end <= 1'b0;
                r_out.point_ok  <= pix_ok;
                r_out.last      <= 1'b1;
            end else begin
                r_out.kind      <= 1'b1;
                r_out.spi_word  <= word;
                r_out.latch_end <= o_sts.col_mod_last;
                r_out.point_ok  <= 1'b0;
                r_out.last      <= o_sts.col_mod_last && grp_last;
            end
        end
    end

    assign o_sts.action       = i_in_data.action;
    assign o_sts.pix_ok       = pix_ok;
    assign o_sts.col_mod_last = (r_col == CW'(MODULES - 1));
    assign o_sts.col_lt_mod   = (r_col < CW'(MODULES));
    assign o_sts.col_roll_end = roll_end;
    assign o_sts.row_last     = (r_row == 3'd7);
    assign o_sts.grp_last     = grp_last;
    assign o_sts.out_free     = out_free;

endmodule

// ===== rtl/led_matrix_frame_serializer.sv =====
// Frame buffer and command serializer for a chain of MODULES 8x8 LED drivers.
// Input channel: one beat per action (pixel, roll, refresh, init, display test,
//   apply intensity). o_in_stall is high from the accepting edge until the
//   last result beat is loaded into the output register or a roll ends.
// Output channel: result beats in order; kind 0 is a pixel status beat, kind 1
//   a 16-bit driver word. latch_end marks the last word of each all-modules
//   group, last marks the final beat of an action.
// Per action: pixel reads and writes back one frame byte (skipped with out-of-range
//   coordinates), refresh sends one frame byte per cycle while the output is not
//   stalled, prefetched while the previous word goes out, and roll runs a
//   read-modify-write over the frame memory, reading one byte while writing back
//   another, and loads no output beat.
//   Action codes six and seven produce nothing.
// Receiver stall: the output register holds its beat; the sequencer waits
//   and resumes without losing or repeating a beat. One result may wait in the
//   output register while the next action is accepted.
// Reset (synchronous, active low): frame reads as all zero via per-entry valid
//   bits, intensity returns to 3, both channels go idle. No clearing pass.
// The user writes intensity (i_cfg_we/i_cfg_data) only while idle; unenforced.
module led_matrix_frame_serializer #(
    parameter int MODULES = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lmfs_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lmfs_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_data
);
    import lmfs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lmfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lmfs_datapath #(
        .MODULES (MODULES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
